/* sv/vu_meter_ballistics_macros.svh */
// Assertion macros for the VU meter ballistics block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef VU_METER_BALLISTICS_MACROS_SVH
`define VU_METER_BALLISTICS_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define VUMB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define VUMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/vumb_pkg.sv */
// Shared types, defaults and register codes for the VU meter ballistics block.
// Holds the gamma table generator used at elaboration. No dependencies.
package vumb_pkg;

   // Default fixed-point fraction bits and elapsed-time clamp
   localparam int unsigned FRAC_BITS_DEF = 8;
   localparam int unsigned MAX_DT_MS_DEF = 80;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_SPEED  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_SPEED = 1'b1;

   // Bits searched per gamma entry (covers 100 << 12)
   localparam int unsigned GAMMA_SEARCH_BITS = 20;

   // Input word
   typedef struct packed {
      logic [15:0] elapsed_ms;
      logic [7:0]  left_raw;
      logic [7:0]  right_raw;
      logic        playing;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [6:0] left_needle;
      logic [6:0] right_needle;
      logic [6:0] left_target;
      logic [6:0] right_target;
   } rsp_word_type;

   // Largest t with t^10 * 255^7 <= (100 << frac)^10 * x^7, i.e.
   // floor((100 << frac) * (x/255)^0.7). Only evaluated at elaboration.
   function automatic int unsigned gamma_entry(input int unsigned x,
                                               input int unsigned frac);
      logic [255:0] rhs;
      logic [255:0] lhs;
      int unsigned  full;
      int unsigned  t;
      int unsigned  cand;
      full = 100 << frac;
      rhs  = 256'd1;
      for (int i = 0; i < 10; i++) rhs = rhs * 256'(full);
      for (int i = 0; i < 7; i++) rhs = rhs * 256'(x);
      t = 0;
      for (int b = GAMMA_SEARCH_BITS - 1; b >= 0; b--) begin
         cand = t | (32'd1 << b);
         if (cand <= full) begin
            lhs = 256'd1;
            for (int i = 0; i < 10; i++) lhs = lhs * 256'(cand);
            for (int i = 0; i < 7; i++) lhs = lhs * 256'd255;
            if (lhs <= rhs) t = cand;
         end
      end
      return t;
   endfunction

endpackage

/* sv/vu_meter_ballistics.sv */
// VU meter needle ballistics: gamma-mapped targets and attack/release slewing.
// Depends on vumb_pkg and vu_meter_ballistics_macros.svh.
//
// Usage:
//   req_* carries one word per tick: elapsed ms, two raw level bytes and a
//   playing flag. rsp_* returns one word per tick: rounded needle levels and
//   truncated targets, both in percent. csr_* writes the attack (index 0) and
//   release (index 1) speed settings; write only while the block is idle.
//   Pipeline: seven registers (input, rate product, whole quotient, scaled
//   remainder, fraction quotient, step assembly and the output register).
//   Throughput: one word per cycle while rsp_stall is low. The only
//   feedback is the needle level, updated by one add and compare in the
//   output stage for each word that enters it.
//   Reset: needle levels go to zero, both speeds to 10, pipeline empties.
//   Stall: when rsp_stall holds a valid result, the output stage holds and
//   earlier stages keep filling their bubbles; req_stall rises once all seven
//   stages carry words. A held result never changes.
`include "vu_meter_ballistics_macros.svh"

module vu_meter_ballistics #(
   parameter int unsigned FRAC_BITS = vumb_pkg::FRAC_BITS_DEF,
   parameter int unsigned MAX_DT_MS = vumb_pkg::MAX_DT_MS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vumb_pkg::req_word_type              req_word,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vumb_pkg::rsp_word_type              rsp_word,
   // configuration writes
   input  logic                                csr_write,
   input  logic [vumb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vumb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import vumb_pkg::*;

   // ---------------------------------------------------------------
   // Constants and widths
   // ---------------------------------------------------------------
   localparam longint unsigned SPEED_MIN   = 1;
   localparam longint unsigned SPEED_MAX   = 20;
   localparam longint unsigned SPEED_RESET = 10;
   localparam longint unsigned ATTACK_BASE  = 220;
   localparam longint unsigned ATTACK_STEP  = 55;
   localparam longint unsigned RELEASE_BASE = 18;
   localparam longint unsigned RELEASE_STEP = 14;
   localparam longint unsigned MS_PER_S    = 1000;
   localparam longint unsigned HALF_MS     = 500;
   localparam longint unsigned NEEDLE_MAX  = 100;

   localparam longint unsigned FULL_SCALE = NEEDLE_MAX << FRAC_BITS;
   localparam longint unsigned ONE_UNIT   = 64'd1 << FRAC_BITS;
   localparam longint unsigned SNAP_LIMIT = ((64'd35 << FRAC_BITS) + 99) / 100;
   localparam int unsigned     LEVEL_W    = $clog2(FULL_SCALE + 1);
   localparam int unsigned     RND_W      = LEVEL_W + 1;

   localparam longint unsigned RATE_MAX = ATTACK_BASE + ATTACK_STEP * SPEED_MAX;
   localparam int unsigned     RATE_W   = $clog2(RATE_MAX + 1);
   localparam int unsigned     DT_W     = $clog2(MAX_DT_MS + 1);

   // rate * dt, and its whole-second part by reciprocal multiply
   localparam longint unsigned PROD_MAX  = RATE_MAX * MAX_DT_MS;
   localparam int unsigned     PROD_W    = $clog2(PROD_MAX + 1);
   localparam int unsigned     SHIFT1    = PROD_W + 10;
   localparam longint unsigned RECIP1    = ((64'd1 << SHIFT1) + MS_PER_S - 1) / MS_PER_S;
   localparam int unsigned     RECIP1_W  = $clog2(RECIP1 + 1);
   localparam int unsigned     MUL1_W    = PROD_W + RECIP1_W;
   localparam longint unsigned WHOLE_MAX = PROD_MAX / MS_PER_S;
   localparam int unsigned     WHOLE_W   = (WHOLE_MAX == 0) ? 1 : $clog2(WHOLE_MAX + 1);

   // remainder scaled by 2^FRAC_BITS plus half, divided again
   localparam int unsigned     REM_W     = 10;
   localparam longint unsigned NUM_MAX   = ((MS_PER_S - 1) << FRAC_BITS) + HALF_MS;
   localparam int unsigned     NUM_W     = $clog2(NUM_MAX + 1);
   localparam int unsigned     SHIFT2    = NUM_W + 10;
   localparam longint unsigned RECIP2    = ((64'd1 << SHIFT2) + MS_PER_S - 1) / MS_PER_S;
   localparam int unsigned     RECIP2_W  = $clog2(RECIP2 + 1);
   localparam int unsigned     MUL2_W    = NUM_W + RECIP2_W;
   localparam int unsigned     FQ_W      = FRAC_BITS + 1;

   localparam longint unsigned STEP_MAX = ((PROD_MAX << FRAC_BITS) + HALF_MS) / MS_PER_S;
   localparam int unsigned     STEP_W   = $clog2(STEP_MAX + 1);
   localparam int unsigned     SUM_W    = ((STEP_W > LEVEL_W) ? STEP_W : LEVEL_W) + 1;

   // pipeline stage positions
   localparam int unsigned NUM_STAGES = 7;
   localparam int unsigned ST_IN    = 0;
   localparam int unsigned ST_MUL   = 1;
   localparam int unsigned ST_RECIP = 2;
   localparam int unsigned ST_REM   = 3;
   localparam int unsigned ST_FRAC  = 4;
   localparam int unsigned ST_STEP  = 5;
   localparam int unsigned ST_OUT   = 6;

   // raw levels travelling alongside the step computation
   typedef struct packed {
      logic [7:0] left_raw;
      logic [7:0] right_raw;
      logic       playing;
   } level_src_type;

   // ---------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------
   function automatic logic [RATE_W-1:0] speed_rate(input logic [CSR_DATA_W-1:0] speed,
                                                    input longint unsigned base,
                                                    input longint unsigned step);
      logic [CSR_DATA_W-1:0] s;
      s = speed;
      if (s < CSR_DATA_W'(SPEED_MIN)) s = CSR_DATA_W'(SPEED_MIN);
      if (s > CSR_DATA_W'(SPEED_MAX)) s = CSR_DATA_W'(SPEED_MAX);
      return RATE_W'(base) + RATE_W'(step) * RATE_W'(s);
   endfunction

   function automatic logic [LEVEL_W-1:0] move_level(input logic [LEVEL_W-1:0] level,
                                                     input logic [LEVEL_W-1:0] target,
                                                     input logic [STEP_W-1:0]  up,
                                                     input logic [STEP_W-1:0]  down);
      logic [SUM_W-1:0]   rise;
      logic [SUM_W-1:0]   gap;
      logic [LEVEL_W-1:0] next;
      rise = SUM_W'(level) + SUM_W'(up);
      gap  = SUM_W'(level - target);
      if (target >= level) begin
         next = (rise < SUM_W'(target)) ? LEVEL_W'(rise) : target;
      end else begin
         next = (gap > SUM_W'(down)) ? level - LEVEL_W'(down) : target;
      end
      // quiet channel: park the needle once it is nearly down
      if (target < LEVEL_W'(ONE_UNIT) && next < LEVEL_W'(SNAP_LIMIT)) next = '0;
      return next;
   endfunction

   function automatic logic [6:0] round_needle(input logic [LEVEL_W-1:0] level);
      logic [RND_W-1:0] r;
      r = (RND_W'(level) + RND_W'(ONE_UNIT >> 1)) >> FRAC_BITS;
      return (r > RND_W'(NEEDLE_MAX)) ? 7'(NEEDLE_MAX) : 7'(r);
   endfunction

   // ---------------------------------------------------------------
   // Gamma table, built at elaboration
   // ---------------------------------------------------------------
   logic [LEVEL_W-1:0] gamma_lut [256];

   for (genvar g = 0; g < 256; g++) begin : g_gamma
      localparam int unsigned ENTRY = gamma_entry(g, FRAC_BITS);
      assign gamma_lut[g] = LEVEL_W'(ENTRY);
   end

   // ---------------------------------------------------------------
   // Speed registers (stored as rates in percent per second)
   // ---------------------------------------------------------------
   logic [RATE_W-1:0] attack_rate_ff, attack_rate_in;
   logic [RATE_W-1:0] release_rate_ff, release_rate_in;

   always_comb begin
      attack_rate_in  = attack_rate_ff;
      release_rate_in = release_rate_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ATTACK_SPEED:  attack_rate_in  = speed_rate(csr_data, ATTACK_BASE,
                                                            ATTACK_STEP);
            CSR_RELEASE_SPEED: release_rate_in = speed_rate(csr_data, RELEASE_BASE,
                                                            RELEASE_STEP);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_rate_ff  <= RATE_W'(ATTACK_BASE + ATTACK_STEP * SPEED_RESET);
         release_rate_ff <= RATE_W'(RELEASE_BASE + RELEASE_STEP * SPEED_RESET);
      end else begin
         attack_rate_ff  <= attack_rate_in;
         release_rate_ff <= release_rate_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control: a stage loads when empty or when it drains
   // ---------------------------------------------------------------
   logic [NUM_STAGES-1:0] stage_valid_ff, stage_valid_in;
   logic [NUM_STAGES-1:0] stage_load;

   assign stage_load[ST_OUT] = !stage_valid_ff[ST_OUT] || !rsp_stall;
   for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_load
      assign stage_load[k] = !stage_valid_ff[k] || stage_load[k+1];
   end

   assign stage_valid_in = {stage_valid_ff[NUM_STAGES-2:0], req_valid};
   assign req_stall      = !stage_load[ST_IN];
   assign rsp_valid      = stage_valid_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= (stage_load & stage_valid_in) | (~stage_load & stage_valid_ff);
      end
   end

   // ---------------------------------------------------------------
   // Stage registers
   // ---------------------------------------------------------------
   logic [DT_W-1:0]    in_dt_ff, in_dt_in;
   level_src_type      in_src_ff;

   logic [PROD_W-1:0]  mul_up_ff, mul_up_in;
   logic [PROD_W-1:0]  mul_dn_ff, mul_dn_in;
   level_src_type      mul_src_ff;

   logic [PROD_W-1:0]  rcp_prod_up_ff, rcp_prod_dn_ff;
   logic [WHOLE_W-1:0] rcp_whole_up_ff, rcp_whole_up_in;
   logic [WHOLE_W-1:0] rcp_whole_dn_ff, rcp_whole_dn_in;
   level_src_type      rcp_src_ff;
   logic [MUL1_W-1:0]  rcp_mul_up, rcp_mul_dn;

   logic [WHOLE_W-1:0] rem_whole_up_ff, rem_whole_dn_ff;
   logic [NUM_W-1:0]   rem_num_up_ff, rem_num_up_in;
   logic [NUM_W-1:0]   rem_num_dn_ff, rem_num_dn_in;
   level_src_type      rem_src_ff;
   logic [REM_W-1:0]   rem_up, rem_dn;

   logic [WHOLE_W-1:0] frq_whole_up_ff, frq_whole_dn_ff;
   logic [FQ_W-1:0]    frq_up_ff, frq_up_in;
   logic [FQ_W-1:0]    frq_dn_ff, frq_dn_in;
   level_src_type      frq_src_ff;
   logic [MUL2_W-1:0]  frq_mul_up, frq_mul_dn;

   logic [STEP_W-1:0]  step_up_ff, step_up_in;
   logic [STEP_W-1:0]  step_dn_ff, step_dn_in;
   logic [LEVEL_W-1:0] step_left_tgt_ff, step_left_tgt_in;
   logic [LEVEL_W-1:0] step_right_tgt_ff, step_right_tgt_in;

   logic [LEVEL_W-1:0] left_level_ff, left_level_in;
   logic [LEVEL_W-1:0] right_level_ff, right_level_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // input stage: clamp elapsed time to 1..MAX_DT_MS
   always_comb begin
      priority if (req_word.elapsed_ms == '0) begin
         in_dt_in = DT_W'(1);
      end else if (req_word.elapsed_ms > 16'(MAX_DT_MS)) begin
         in_dt_in = DT_W'(MAX_DT_MS);
      end else begin
         in_dt_in = DT_W'(req_word.elapsed_ms);
      end
   end

   // rate times elapsed ms
   assign mul_up_in = PROD_W'(attack_rate_ff) * PROD_W'(in_dt_ff);
   assign mul_dn_in = PROD_W'(release_rate_ff) * PROD_W'(in_dt_ff);

   // whole part of product / 1000
   assign rcp_mul_up      = MUL1_W'(mul_up_ff) * MUL1_W'(RECIP1);
   assign rcp_mul_dn      = MUL1_W'(mul_dn_ff) * MUL1_W'(RECIP1);
   assign rcp_whole_up_in = WHOLE_W'(rcp_mul_up >> SHIFT1);
   assign rcp_whole_dn_in = WHOLE_W'(rcp_mul_dn >> SHIFT1);

   // remainder, scaled to fraction bits, plus half for rounding
   assign rem_up = REM_W'(rcp_prod_up_ff - PROD_W'(rcp_whole_up_ff) * PROD_W'(MS_PER_S));
   assign rem_dn = REM_W'(rcp_prod_dn_ff - PROD_W'(rcp_whole_dn_ff) * PROD_W'(MS_PER_S));
   assign rem_num_up_in = (NUM_W'(rem_up) << FRAC_BITS) + NUM_W'(HALF_MS);
   assign rem_num_dn_in = (NUM_W'(rem_dn) << FRAC_BITS) + NUM_W'(HALF_MS);

   // fractional part of the step: scaled remainder / 1000
   assign frq_mul_up = MUL2_W'(rem_num_up_ff) * MUL2_W'(RECIP2);
   assign frq_mul_dn = MUL2_W'(rem_num_dn_ff) * MUL2_W'(RECIP2);
   assign frq_up_in  = FQ_W'(frq_mul_up >> SHIFT2);
   assign frq_dn_in  = FQ_W'(frq_mul_dn >> SHIFT2);

   // step assembly and target lookup
   assign step_up_in = (STEP_W'(frq_whole_up_ff) << FRAC_BITS) + STEP_W'(frq_up_ff);
   assign step_dn_in = (STEP_W'(frq_whole_dn_ff) << FRAC_BITS) + STEP_W'(frq_dn_ff);
   assign step_left_tgt_in  = frq_src_ff.playing ? gamma_lut[frq_src_ff.left_raw] : '0;
   assign step_right_tgt_in = frq_src_ff.playing ? gamma_lut[frq_src_ff.right_raw] : '0;

   // output stage: slew the needles and format the result word
   always_comb begin
      left_level_in  = move_level(left_level_ff, step_left_tgt_ff, step_up_ff, step_dn_ff);
      right_level_in = move_level(right_level_ff, step_right_tgt_ff, step_up_ff, step_dn_ff);
      rsp_word_in.left_needle  = round_needle(left_level_in);
      rsp_word_in.right_needle = round_needle(right_level_in);
      rsp_word_in.left_target  = 7'(step_left_tgt_ff >> FRAC_BITS);
      rsp_word_in.right_target = 7'(step_right_tgt_ff >> FRAC_BITS);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (stage_load[ST_IN]) begin
         in_dt_ff  <= in_dt_in;
         in_src_ff <= '{left_raw: req_word.left_raw, right_raw: req_word.right_raw,
                        playing: req_word.playing};
      end
      if (stage_load[ST_MUL]) begin
         mul_up_ff  <= mul_up_in;
         mul_dn_ff  <= mul_dn_in;
         mul_src_ff <= in_src_ff;
      end
      if (stage_load[ST_RECIP]) begin
         rcp_prod_up_ff  <= mul_up_ff;
         rcp_prod_dn_ff  <= mul_dn_ff;
         rcp_whole_up_ff <= rcp_whole_up_in;
         rcp_whole_dn_ff <= rcp_whole_dn_in;
         rcp_src_ff      <= mul_src_ff;
      end
      if (stage_load[ST_REM]) begin
         rem_whole_up_ff <= rcp_whole_up_ff;
         rem_whole_dn_ff <= rcp_whole_dn_ff;
         rem_num_up_ff   <= rem_num_up_in;
         rem_num_dn_ff   <= rem_num_dn_in;
         rem_src_ff      <= rcp_src_ff;
      end
      if (stage_load[ST_FRAC]) begin
         frq_whole_up_ff <= rem_whole_up_ff;
         frq_whole_dn_ff <= rem_whole_dn_ff;
         frq_up_ff       <= frq_up_in;
         frq_dn_ff       <= frq_dn_in;
         frq_src_ff      <= rem_src_ff;
      end
      if (stage_load[ST_STEP]) begin
         step_up_ff        <= step_up_in;
         step_dn_ff        <= step_dn_in;
         step_left_tgt_ff  <= step_left_tgt_in;
         step_right_tgt_ff <= step_right_tgt_in;
      end
      if (stage_load[ST_OUT]) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // needle state advances only with a real word entering the output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         left_level_ff  <= '0;
         right_level_ff <= '0;
      end else if (stage_load[ST_OUT] && stage_valid_ff[ST_STEP]) begin
         left_level_ff  <= left_level_in;
         right_level_ff <= right_level_in;
      end
   end

   assign rsp_word = rsp_word_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   logic                 levels_in_range;
   logic                 rsp_held;
   logic [2*LEVEL_W-1:0] needle_levels;
   logic                 step_valid;
   logic                 steps_nonzero;

   assign levels_in_range = left_level_ff <= LEVEL_W'(FULL_SCALE) &&
                            right_level_ff <= LEVEL_W'(FULL_SCALE);
   assign rsp_held        = rsp_valid && rsp_stall;
   assign needle_levels   = {left_level_ff, right_level_ff};
   assign step_valid      = stage_valid_ff[ST_STEP];
   assign steps_nonzero   = step_up_ff != '0 && step_dn_ff != '0;

   `VUMB_ASSERT_NOW(a_level_bound, clock, reset, 1'b1, levels_in_range, "level above full scale")
   `VUMB_ASSERT_NEXT(a_level_hold, clock, reset, rsp_held, $stable(needle_levels), "level moved")
   `VUMB_ASSERT_NOW(a_step_nonzero, clock, reset, step_valid, steps_nonzero, "zero slew step")

endmodule

/* tb/sv/vu_meter_ballistics_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for vu_meter_ballistics: predicts each result word from
// its own needle model and compares field by field. Depends on vumb_pkg and the RTL.
module vu_meter_ballistics_test;
   import vumb_pkg::*;

   localparam int unsigned FRAC       = FRAC_BITS_DEF;
   localparam int unsigned MAX_DT     = MAX_DT_MS_DEF;
   localparam int unsigned FULL_SCALE = 100 << FRAC;
   localparam int unsigned ONE_UNIT   = 1 << FRAC;
   localparam int unsigned SNAP_BELOW = ((35 << FRAC) + 99) / 100;
   localparam int unsigned SETTLE_CYC = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ATTACK_SPEED;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   vu_meter_ballistics u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Needle model state and settings
   int unsigned gamma_lut [256];
   logic [14:0] left_level = '0;
   logic [14:0] right_level = '0;
   logic [4:0]  attack_setting = 5'd10;
   logic [4:0]  release_setting = 5'd10;

   req_word_type pending_words [$];
   rsp_word_type expected_words [$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int unsigned left_prev = 0;
   int unsigned right_prev = 0;

   // Exact test: t^10 * 255^7 <= FULL_SCALE^10 * x^7
   function automatic bit gamma_fits(input int unsigned t, input int unsigned x);
      logic [255:0] lhs;
      logic [255:0] rhs;
      lhs = 256'd1;
      rhs = 256'd1;
      for (int i = 0; i < 10; i++) begin
         lhs = lhs * 256'(t);
         rhs = rhs * 256'(FULL_SCALE);
      end
      for (int i = 0; i < 7; i++) begin
         lhs = lhs * 256'd255;
         rhs = rhs * 256'(x);
      end
      return lhs <= rhs;
   endfunction

   function automatic int unsigned speed_clamp(input logic [4:0] s);
      if (s < 1) return 1;
      if (s > 20) return 20;
      return 32'(s);
   endfunction

   // Per-tick move, rate in percent per second, halves round up
   function automatic int unsigned slew_step(input int unsigned rate, input int unsigned dt);
      return (((rate * dt) << FRAC) + 500) / 1000;
   endfunction

   function automatic int unsigned slew_level(input int unsigned lvl, input int unsigned tgt,
                                              input int unsigned up, input int unsigned down);
      int unsigned n;
      if (tgt >= lvl) begin
         n = lvl + up;
         n = (n < tgt) ? n : tgt;
      end else begin
         n = (lvl - tgt > down) ? lvl - down : tgt;
      end
      // snap to rest near zero when the target is under one percent
      if (tgt < ONE_UNIT && n < SNAP_BELOW) n = 0;
      return n;
   endfunction

   function automatic int unsigned needle_round(input int unsigned lvl);
      int unsigned r;
      r = (lvl + (ONE_UNIT >> 1)) >> FRAC;
      return (r > 100) ? 100 : r;
   endfunction

   // Advance the needle model by one tick and return the expected word
   function automatic rsp_word_type needle_predict(input req_word_type w);
      int unsigned dt;
      int unsigned lt;
      int unsigned rt;
      int unsigned up;
      int unsigned down;
      rsp_word_type r;
      dt = 32'(w.elapsed_ms);
      if (dt < 1) dt = 1;
      if (dt > MAX_DT) dt = MAX_DT;
      lt = w.playing ? gamma_lut[w.left_raw] : 0;
      rt = w.playing ? gamma_lut[w.right_raw] : 0;
      up = slew_step(220 + 55 * speed_clamp(attack_setting), dt);
      down = slew_step(18 + 14 * speed_clamp(release_setting), dt);
      left_level = 15'(slew_level(32'(left_level), lt, up, down));
      right_level = 15'(slew_level(32'(right_level), rt, up, down));
      r.left_needle = 7'(needle_round(32'(left_level)));
      r.right_needle = 7'(needle_round(32'(right_level)));
      r.left_target = 7'(lt >> FRAC);
      r.right_target = 7'(rt >> FRAC);
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   task automatic push_word(input int unsigned ms, input int unsigned l, input int unsigned r,
                            input bit p);
      req_word_type w;
      w.elapsed_ms = 16'(ms);
      w.left_raw = 8'(l);
      w.right_raw = 8'(r);
      w.playing = p;
      pending_words.push_back(w);
   endtask

   // Extremes of every field, not-playing, saturation and the snap to zero
   task automatic add_directed_words();
      push_word(0, 0, 0, 1);
      push_word(1, 255, 255, 1);
      push_word(80, 255, 255, 1);
      push_word(80, 255, 255, 1);
      push_word(80, 255, 255, 1);
      push_word(65535, 255, 0, 1);
      push_word(81, 0, 255, 0);
      push_word(0, 0, 0, 0);
      push_word(1, 1, 1, 1);
      push_word(1, 0, 0, 1);
      push_word(1, 0, 0, 1);
      push_word(1, 0, 0, 1);
      push_word(5, 1, 128, 1);
      push_word(2, 0, 0, 1);
      push_word(40, 128, 64, 1);
      push_word(16'hAAAA, 8'h55, 8'hAA, 1);
      push_word(16'h5555, 8'hAA, 8'h55, 0);
      push_word(3, 200, 17, 1);
      push_word(79, 254, 2, 1);
      push_word(1, 0, 0, 1);
      push_word(1, 0, 0, 1);
      push_word(1, 0, 0, 1);
   endtask

   function automatic int unsigned next_raw(input int unsigned prev);
      int unsigned sel;
      int v;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 0;
         1: return 255;
         2, 3: return $urandom_range(0, 16);
         4: return $urandom_range(0, 255);
         default: begin
            // drift like a real signal envelope
            v = int'(prev) + int'($urandom_range(0, 60)) - 30;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return v;
         end
      endcase
   endfunction

   task automatic add_random_words(input int count);
      int unsigned sel;
      int unsigned ms;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 75) ms = $urandom_range(1, 80);
         else if (sel < 85) ms = $urandom_range(0, 1);
         else if (sel < 94) ms = $urandom_range(81, 1000);
         else ms = $urandom_range(0, 65535);
         left_prev = next_raw(left_prev);
         right_prev = next_raw(right_prev);
         push_word(ms, left_prev, right_prev, $urandom_range(0, 7) != 0);
      end
   endtask

   task automatic write_speed(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_ATTACK_SPEED) attack_setting = 5'(val);
      else release_setting = 5'(val);
   endtask

   // Wait until every word is sent and answered, then let the pipe empty
   task automatic settle();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Driver: bursts of words with random gaps, holding a stalled word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_words.push_back(needle_predict(req_word));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Monitor: check accepted results and drive the receiver stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   int stall_mode_left = 0;
   int unsigned stall_phase = 0;
   rsp_word_type exp_w;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $time, rsp_word);
            mismatches++;
         end else begin
            exp_w = expected_words.pop_front();
            check_field("left_needle", 32'(exp_w.left_needle), 32'(rsp_word.left_needle));
            check_field("right_needle", 32'(exp_w.right_needle), 32'(rsp_word.right_needle));
            check_field("left_target", 32'(exp_w.left_target), 32'(rsp_word.left_target));
            check_field("right_target", 32'(exp_w.right_target), 32'(rsp_word.right_target));
         end
      end
      if (stall_mode_left <= 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_mode_left = $urandom_range(20, 300);
      end
      stall_mode_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
         default:      rsp_stall <= ((stall_phase % 7) < 3);
      endcase
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   int unsigned attack_plan [8];
   int unsigned release_plan [8];
   int unsigned guess;

   initial begin
      // Gamma table: floating-point estimate, then exact integer correction
      for (int x = 0; x < 256; x++) begin
         guess = $rtoi(real'(FULL_SCALE) * ((real'(x) / 255.0) ** 0.7));
         if (guess > FULL_SCALE) guess = FULL_SCALE;
         while (guess < FULL_SCALE && gamma_fits(guess + 1, x)) guess++;
         while (guess > 0 && !gamma_fits(guess, x)) guess--;
         gamma_lut[x] = guess;
      end
      attack_plan = '{1, 20, 0, 31, 21, 0, 0, 0};
      release_plan = '{1, 20, 31, 0, 2, 0, 0, 0};
      for (int p = 5; p < 8; p++) begin
         attack_plan[p] = $urandom_range(0, 31);
         release_plan[p] = $urandom_range(0, 31);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset speeds first
      add_directed_words();
      add_random_words(130);
      settle();

      for (int p = 0; p < 8; p++) begin
         write_speed(CSR_ATTACK_SPEED, attack_plan[p]);
         write_speed(CSR_RELEASE_SPEED, release_plan[p]);
         add_random_words(130);
         settle();
      end

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
